// File: rtl/skrs_pkg.sv
// ----------------------------------------------------------------------------
// skrs_pkg
// Shared constants, types and the cumulative mass table of the spline kernel
// radius sampler. The table is worked out once at elaboration.
// ----------------------------------------------------------------------------
package skrs_pkg;

    // grid of evenly spaced radii, power of two so the final scaling is a shift
    localparam int GRID_INTERVALS = 256;
    localparam int LO_W           = $clog2(GRID_INTERVALS);
    localparam int ADDR_W         = LO_W + 1;

    localparam int ENTRY_W        = 33;
    localparam int FRAC_W         = 32;

    localparam int DIV_STEPS      = FRAC_W;
    localparam int CNT_W          = $clog2(DIV_STEPS);

    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    typedef logic [ENTRY_W-1:0] t_entry;
    typedef t_entry t_table [0:GRID_INTERVALS];

    // one interpolation job handed from the search to the divider
    typedef struct packed {
        logic [FRAC_W-1:0]  num;
        logic [ENTRY_W-1:0] den;
        logic [LO_W-1:0]    lo;
    } t_job;

    typedef enum logic [2:0] {
        F_IDLE,
        F_ADDR,
        F_CMP,
        F_RD_LO,
        F_RD_HI,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_RUN,
        B_DONE
    } t_back_state;

    localparam longint unsigned Q31_ONE  = 64'd2147483648;
    localparam longint          Q31_ONES = 64'sd2147483648;

    function automatic longint unsigned mul_q31(input longint unsigned a,
                                                input longint unsigned b);
        return (a * b + (Q31_ONE >> 1)) >> 31;
    endfunction

    // cumulative mass at each grid radius, Q1.32, made non-decreasing
    function automatic t_table build_table();
        t_table            tbl;
        longint unsigned   kk;
        longint unsigned   u;
        longint unsigned   p2, p3, p4, p5, p6;
        longint unsigned   v;
        longint unsigned   prev;
        longint            s;
        prev = 64'd0;
        for (int k = 0; k <= GRID_INTERVALS; k++) begin
            kk = longint'(k);
            u  = ((kk << 31) + longint'(GRID_INTERVALS / 2)) / GRID_INTERVALS;
            if (u > Q31_ONE)
                u = Q31_ONE;
            p2 = mul_q31(u, u);
            p3 = mul_q31(p2, u);
            p4 = mul_q31(p3, u);
            p5 = mul_q31(p4, u);
            p6 = mul_q31(p5, u);
            if (k * 2 < GRID_INTERVALS)
                s = 160 * $signed(p3) - 576 * $signed(p5) + 480 * $signed(p6);
            else
                s = -Q31_ONES + 320 * $signed(p3) - 720 * $signed(p4)
                    + 576 * $signed(p5) - 160 * $signed(p6);
            if (s < 0)
                s = 0;
            if (s > 15 * Q31_ONES)
                s = 15 * Q31_ONES;
            v = (2 * $unsigned(s) + 64'd7) / 15;
            if (v < prev)
                v = prev;
            tbl[k] = v[ENTRY_W-1:0];
            prev = v;
        end
        tbl[0]              = '0;
        tbl[GRID_INTERVALS] = {1'b1, {(ENTRY_W-1){1'b0}}};
        return tbl;
    endfunction

    localparam t_table MASS_TABLE = build_table();

endpackage

// File: rtl/skrs_front.sv
// ----------------------------------------------------------------------------
// skrs_front
// Accepts a uniform word, bisects the cumulative mass table for its interval
// and hands numerator, interval width and index to the job queue.
// ----------------------------------------------------------------------------
module skrs_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    output logic                       o_full,
    input  logic [31:0]                i_uniform_fraction,
    output logic                       o_job_push,
    output skrs_pkg::t_job             o_job,
    input  logic                       i_job_full
);

    skrs_pkg::t_front_state           r_state, n_state;
    logic [31:0]                      r_x, n_x;
    logic [skrs_pkg::LO_W-1:0]        r_lo, n_lo;
    logic [skrs_pkg::ADDR_W-1:0]      r_hi, n_hi;
    logic [skrs_pkg::ENTRY_W-1:0]     r_t_lo, n_t_lo;
    logic [skrs_pkg::ENTRY_W-1:0]     r_rom_q;

    logic [skrs_pkg::ADDR_W-1:0]      rom_addr;
    logic [skrs_pkg::ADDR_W-1:0]      span_sum;
    logic [skrs_pkg::LO_W-1:0]        mid;
    logic [skrs_pkg::ADDR_W-1:0]      width_left;

    assign span_sum   = {1'b0, r_lo} + r_hi;
    assign mid        = span_sum[skrs_pkg::ADDR_W-1:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= skrs_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x     <= n_x;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_t_lo  <= n_t_lo;
        // registered table read
        r_rom_q <= skrs_pkg::MASS_TABLE[rom_addr];
    end

    always_comb begin
        n_state    = r_state;
        n_x        = r_x;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_t_lo     = r_t_lo;
        rom_addr   = '0;
        width_left = '0;
        o_full     = 1'b1;
        o_job_push = 1'b0;
        o_job.num  = r_x - r_t_lo[31:0];
        o_job.den  = r_rom_q - r_t_lo;
        o_job.lo   = r_lo;
        unique case (r_state)
            skrs_pkg::F_IDLE: begin
                o_full = 1'b0;
                if (i_push) begin
                    n_x     = i_uniform_fraction;
                    n_lo    = '0;
                    n_hi    = skrs_pkg::ADDR_W'(skrs_pkg::GRID_INTERVALS);
                    n_state = skrs_pkg::F_ADDR;
                end
            end
            skrs_pkg::F_ADDR: begin
                rom_addr = {1'b0, mid};
                n_state  = skrs_pkg::F_CMP;
            end
            skrs_pkg::F_CMP: begin
                if (r_rom_q <= {1'b0, r_x})
                    n_lo = mid;
                else
                    n_hi = {1'b0, mid};
                width_left = n_hi - {1'b0, n_lo};
                if (width_left > skrs_pkg::ADDR_W'(1))
                    n_state = skrs_pkg::F_ADDR;
                else
                    n_state = skrs_pkg::F_RD_LO;
            end
            skrs_pkg::F_RD_LO: begin
                rom_addr = {1'b0, r_lo};
                n_state  = skrs_pkg::F_RD_HI;
            end
            skrs_pkg::F_RD_HI: begin
                rom_addr = {1'b0, r_lo} + skrs_pkg::ADDR_W'(1);
                n_t_lo   = r_rom_q;
                n_state  = skrs_pkg::F_PUSH;
            end
            skrs_pkg::F_PUSH: begin
                // keep the upper entry on the read port while the queue is full
                rom_addr = {1'b0, r_lo} + skrs_pkg::ADDR_W'(1);
                if (!i_job_full) begin
                    o_job_push = 1'b1;
                    n_state    = skrs_pkg::F_IDLE;
                end
            end
            default: begin
                n_state = skrs_pkg::F_IDLE;
            end
        endcase
    end

    // the found interval must hold the word, so the quotient stays below one
    a_num_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_push |-> ({1'b0, o_job.num} < o_job.den))
        else $error("interval search gave numerator not below width");

    // the search never narrows to an empty range
    a_hi_above_lo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == skrs_pkg::F_ADDR) |-> (r_hi > {1'b0, r_lo}))
        else $error("bisection bounds crossed");

endmodule

// File: rtl/skrs_fifo.sv
// ----------------------------------------------------------------------------
// skrs_fifo
// Short job queue between the table search and the divider.
// ----------------------------------------------------------------------------
module skrs_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  skrs_pkg::t_job   i_data,
    output logic             o_full,
    input  logic             i_pop,
    output skrs_pkg::t_job   o_data,
    output logic             o_empty
);

    skrs_pkg::t_job                 r_mem [0:skrs_pkg::QUEUE_DEPTH-1];
    logic [skrs_pkg::QPTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [skrs_pkg::QPTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [skrs_pkg::QCNT_W-1:0]    r_count, n_count;
    logic                           do_push, do_pop;

    assign o_full  = (r_count == skrs_pkg::QCNT_W'(skrs_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push)
            n_wr_ptr = (r_wr_ptr == skrs_pkg::QPTR_W'(skrs_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_wr_ptr + skrs_pkg::QPTR_W'(1);
        if (do_pop)
            n_rd_ptr = (r_rd_ptr == skrs_pkg::QPTR_W'(skrs_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_rd_ptr + skrs_pkg::QPTR_W'(1);
        if (do_push && !do_pop)
            n_count = r_count + skrs_pkg::QCNT_W'(1);
        else if (do_pop && !do_push)
            n_count = r_count - skrs_pkg::QCNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push)
            r_mem[r_wr_ptr] <= i_data;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= skrs_pkg::QCNT_W'(skrs_pkg::QUEUE_DEPTH))
        else $error("job queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("job pushed into full queue");

endmodule

// File: rtl/skrs_back.sv
// ----------------------------------------------------------------------------
// skrs_back
// Restoring divider for the in-interval fraction, index scaling and the
// output register.
// ----------------------------------------------------------------------------
module skrs_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_empty,
    input  skrs_pkg::t_job   i_job,
    output logic             o_job_pop,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [31:0]      o_radius
);

    skrs_pkg::t_back_state            r_state, n_state;
    logic [skrs_pkg::ENTRY_W-1:0]     r_rem, n_rem;
    logic [skrs_pkg::ENTRY_W-1:0]     r_den, n_den;
    logic [skrs_pkg::FRAC_W-1:0]      r_quot, n_quot;
    logic [skrs_pkg::LO_W-1:0]        r_lo, n_lo;
    logic [skrs_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic                             r_out_valid, n_out_valid;
    logic [31:0]                      r_radius, n_radius;

    logic [skrs_pkg::ENTRY_W:0]       two_rem;
    logic [skrs_pkg::ENTRY_W:0]       sub_rem;
    logic                             q_bit;
    logic                             take;
    logic [skrs_pkg::LO_W+31:0]       scaled;

    assign two_rem = {r_rem, 1'b0};
    assign sub_rem = two_rem - {1'b0, r_den};
    assign q_bit   = (two_rem >= {1'b0, r_den});
    assign take    = i_pop && r_out_valid;
    // index plus fraction over the grid count is a right shift
    assign scaled  = {r_lo, r_quot};

    assign o_empty  = !r_out_valid;
    assign o_radius = r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= skrs_pkg::B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem    <= n_rem;
        r_den    <= n_den;
        r_quot   <= n_quot;
        r_lo     <= n_lo;
        r_cnt    <= n_cnt;
        r_radius <= n_radius;
    end

    always_comb begin
        n_state     = r_state;
        n_rem       = r_rem;
        n_den       = r_den;
        n_quot      = r_quot;
        n_lo        = r_lo;
        n_cnt       = r_cnt;
        n_radius    = r_radius;
        n_out_valid = r_out_valid && !take;
        o_job_pop   = 1'b0;
        unique case (r_state)
            skrs_pkg::B_IDLE: begin
                if (!i_job_empty) begin
                    o_job_pop = 1'b1;
                    n_rem     = {1'b0, i_job.num};
                    n_den     = i_job.den;
                    n_lo      = i_job.lo;
                    n_cnt     = '0;
                    n_state   = skrs_pkg::B_RUN;
                end
            end
            skrs_pkg::B_RUN: begin
                if (q_bit)
                    n_rem = sub_rem[skrs_pkg::ENTRY_W-1:0];
                else
                    n_rem = two_rem[skrs_pkg::ENTRY_W-1:0];
                n_quot = {r_quot[skrs_pkg::FRAC_W-2:0], q_bit};
                n_cnt  = r_cnt + skrs_pkg::CNT_W'(1);
                if (r_cnt == skrs_pkg::CNT_W'(skrs_pkg::DIV_STEPS - 1))
                    n_state = skrs_pkg::B_DONE;
            end
            skrs_pkg::B_DONE: begin
                // wait here while the previous word is still unread
                if (!r_out_valid || take) begin
                    n_radius    = scaled[skrs_pkg::LO_W+31:skrs_pkg::LO_W];
                    n_out_valid = 1'b1;
                    n_state     = skrs_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = skrs_pkg::B_IDLE;
            end
        endcase
    end

    // restoring division leaves a remainder below the divisor
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == skrs_pkg::B_DONE) |-> (r_rem < r_den))
        else $error("divider remainder not reduced");

    // a waiting word is never overwritten before it is read
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop) |=> (r_out_valid && $stable(r_radius)))
        else $error("unread radius word changed");

endmodule

// File: rtl/spline_kernel_radius_sampler.sv
// the 32-step restoring divider sets the rate and takes a job only when the last is done
// the table search runs ahead of the divider, with up to two jobs waiting in the queue
// a finished radius waits in the output register while the divider goes on
// reset (i_rst_n low at a clock edge) empties the queue and the output; no clearing pass
// ----------------------------------------------------------------------------
// spline_kernel_radius_sampler
// Inverse-transform sampling of the cubic-spline kernel mass: table bisection
// in the front, interpolation division in the back, a job queue in between.
// ----------------------------------------------------------------------------
module spline_kernel_radius_sampler (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic [31:0]   i_uniform_fraction,
    output logic          o_empty,
    input  logic          i_pop,
    output logic [31:0]   o_radius
);

    skrs_pkg::t_job   front_job;
    logic             front_push;
    logic             queue_full;
    skrs_pkg::t_job   back_job;
    logic             back_pop;
    logic             queue_empty;

    skrs_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (i_push),
        .o_full             (o_full),
        .i_uniform_fraction (i_uniform_fraction),
        .o_job_push         (front_push),
        .o_job              (front_job),
        .i_job_full         (queue_full)
    );

    skrs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_job),
        .o_full  (queue_full),
        .i_pop   (back_pop),
        .o_data  (back_job),
        .o_empty (queue_empty)
    );

    skrs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (queue_empty),
        .i_job       (back_job),
        .o_job_pop   (back_pop),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_radius    (o_radius)
    );

endmodule
